// ===== rtl/core/kdps_pkg.sv =====
// kdps_pkg: shared types, codes and constants of the kd-tree photon search block
// used by the cfg interface and by every module of rtl/core
package kdps_pkg;

  localparam int TREE_SLOTS_DEFAULT = 1024;
  localparam int HEAP_DEPTH_DEFAULT = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_INDEX_W-1:0] CFG_NEAREST_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_DISTANCE = 2'd1;

  localparam logic [6:0] NEAREST_COUNT_RESET = 7'd16;
  localparam logic [30:0] START_DISTANCE_RESET = 31'd65536;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_RADIUS = 2'd1;
  localparam logic [1:0] KIND_NEAREST = 2'd2;

  localparam logic [2:0] SPLIT_LEAF = 3'd0;
  localparam logic [2:0] SPLIT_X = 3'd1;
  localparam logic [2:0] SPLIT_Y = 3'd2;
  localparam logic [2:0] SPLIT_Z = 3'd3;
  localparam logic [2:0] SPLIT_ABSENT = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_BAD_SPLIT = 2'd2;

  localparam logic [10:0] COUNT_MAX = 11'd2047;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_LOAD_BAD = 3'd1,
    OP_RADIUS = 3'd2,
    OP_NEAREST = 3'd3,
    OP_NOP = 3'd4
  } op_t;

  typedef struct packed {
    op_t op;
    logic [9:0] node_index;
    logic [2:0] split_code;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic [15:0] shape_id;
    logic [47:0] power;
    logic [30:0] search_radius;
  } cmd_t;

  typedef struct packed {
    logic [6:0] nearest_count;
    logic [30:0] start_distance;
  } cfg_t;

  typedef struct packed {
    logic clear_done;
  } back_status_t;

  typedef struct packed {
    logic start;
    logic [63:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic done;
    logic [31:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] sum_red;
    logic [31:0] sum_green;
    logic [31:0] sum_blue;
    logic [10:0] photon_count;
    logic [10:0] same_shape_count;
    logic [63:0] foreign_distance_sq;
    logic [31:0] nearest_radius;
  } result_t;

endpackage

// ===== rtl/core/kdps_if.sv =====
// kdps interfaces: request, result and configuration channels
// depends on kdps_pkg for the configuration port widths
interface kdps_in_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [9:0] node_index;
  logic [2:0] split_code;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [15:0] shape_id;
  logic [15:0] power_red;
  logic [15:0] power_green;
  logic [15:0] power_blue;
  logic [30:0] search_radius;

  modport source (
    output valid, kind, node_index, split_code, coord_x, coord_y, coord_z, shape_id,
    output power_red, power_green, power_blue, search_radius,
    input ready
  );
  modport sink (
    input valid, kind, node_index, split_code, coord_x, coord_y, coord_z, shape_id,
    input power_red, power_green, power_blue, search_radius,
    output ready
  );
endinterface

interface kdps_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [31:0] sum_red;
  logic [31:0] sum_green;
  logic [31:0] sum_blue;
  logic [10:0] photon_count;
  logic [10:0] same_shape_count;
  logic [63:0] foreign_distance_sq;
  logic [31:0] nearest_radius;

  modport source (
    output valid, status, sum_red, sum_green, sum_blue, photon_count, same_shape_count,
    output foreign_distance_sq, nearest_radius,
    input ready
  );
  modport sink (
    input valid, status, sum_red, sum_green, sum_blue, photon_count, same_shape_count,
    input foreign_distance_sq, nearest_radius,
    output ready
  );
endinterface

interface kdps_cfg_if import kdps_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/kd_tree_photon_search_top.sv =====
// Photon search on an implicit kd-tree held in on-chip memory.
// Channels: item (requests: node loads, radius queries, k-nearest queries),
// result (one result per request, in request order) and cfg (register writes,
// always ready: index 0 nearest_count, index 1 start_distance).
// A front stage classifies each request and queues it, two deep, for the back
// end, which owns the node memory and walks the tree one node at a time.
// A load or unused kind goes straight from the queue to the result register.
// A query reads each split node it enters and reads it again on the way back,
// reads each leaf or absent node once and tests each photon it reaches, all
// through the single read port of the node memory; a k-nearest query rescans
// its kept photons on every replacement once its set is full, and ends with a
// square root of the largest kept distance when it kept any photon and met no bad split.
// After reset the node memory is swept to absent, one slot per cycle, over all
// TREE_SLOTS slots; item.ready stays low meanwhile, cfg writes are taken.
// A stalled result holds in the output register; the queue still takes up to
// two further requests while the back end waits.
// Depends on kdps_pkg, kdps_if, kdps_front, kdps_fifo, kdps_back, kdps_sqrt.
module kd_tree_photon_search_top import kdps_pkg::*; #(
  parameter int TREE_SLOTS = TREE_SLOTS_DEFAULT,
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  kdps_in_if.sink item,
  kdps_out_if.source result,
  kdps_cfg_if.sink cfg
);
  back_status_t back_status;
  cfg_t cfg_regs;
  logic q_full;
  logic q_push;
  cmd_t push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t pop_cmd;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  kdps_front #(.TREE_SLOTS(TREE_SLOTS)) u_front (
    .clk(clk), .rst(rst), .item(item), .cfg(cfg), .back_status(back_status),
    .q_full(q_full), .q_push(q_push), .q_cmd(push_cmd), .cfg_regs(cfg_regs)
  );

  kdps_fifo u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .push_data(push_cmd), .full(q_full),
    .pop(q_pop), .pop_data(pop_cmd), .valid(q_valid)
  );

  kdps_back #(.TREE_SLOTS(TREE_SLOTS), .HEAP_DEPTH(HEAP_DEPTH)) u_back (
    .clk(clk), .rst(rst), .cfg_regs(cfg_regs), .q_valid(q_valid), .q_cmd(pop_cmd),
    .q_pop(q_pop), .back_status(back_status), .sqrt_req(sqrt_req),
    .sqrt_rsp(sqrt_rsp), .result(result)
  );

  kdps_sqrt u_sqrt (
    .clk(clk), .rst(rst), .req(sqrt_req), .rsp(sqrt_rsp)
  );
endmodule

// ===== rtl/core/kdps_fifo.sv =====
// kdps_fifo: short command queue between the front and the back
// depends on kdps_pkg for cmd_t and the queue depth
module kdps_fifo import kdps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic valid
);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && valid) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push && !full) - CW'(pop && valid);
    end
  end
endmodule

// ===== rtl/core/kdps_front.sv =====
// kdps_front: takes requests and configuration writes, classifies each request
// depends on kdps_pkg and kdps_if
module kdps_front import kdps_pkg::*; #(
  parameter int TREE_SLOTS = TREE_SLOTS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  kdps_in_if.sink item,
  kdps_cfg_if.sink cfg,
  input  back_status_t back_status,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_cmd,
  output cfg_t cfg_regs
);
  assign item.ready = !q_full && back_status.clear_done;
  assign q_push = item.valid && item.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    q_cmd.node_index = item.node_index;
    q_cmd.split_code = item.split_code;
    q_cmd.coord_x = item.coord_x;
    q_cmd.coord_y = item.coord_y;
    q_cmd.coord_z = item.coord_z;
    q_cmd.shape_id = item.shape_id;
    q_cmd.power = {item.power_red, item.power_green, item.power_blue};
    q_cmd.search_radius = item.search_radius;
    case (item.kind)
      KIND_LOAD: begin
        if (item.node_index == '0 || 32'(item.node_index) >= 32'(TREE_SLOTS)) begin
          q_cmd.op = OP_LOAD_BAD;
        end else begin
          q_cmd.op = OP_LOAD;
        end
      end
      KIND_RADIUS: q_cmd.op = OP_RADIUS;
      KIND_NEAREST: q_cmd.op = OP_NEAREST;
      default: q_cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.nearest_count <= NEAREST_COUNT_RESET;
      cfg_regs.start_distance <= START_DISTANCE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_NEAREST_COUNT: cfg_regs.nearest_count <= cfg.data[6:0];
        CFG_START_DISTANCE: cfg_regs.start_distance <= cfg.data;
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/core/kdps_sqrt.sv =====
// kdps_sqrt: iterative integer square root, one result bit per cycle
// depends on kdps_pkg for the request and response structs
module kdps_sqrt import kdps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);
  logic busy;
  logic done;
  logic [4:0] step;
  logic [63:0] rem;
  logic [63:0] root;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = root + bitv;
  assign rsp = '{done: done, root: root[31:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        rem <= req.value;
        root <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        step <= step + 1'b1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/kdps_back.sv =====
// kdps_back: node store, tree walker, nearest set and result register
// depends on kdps_pkg, kdps_if and the kdps_sqrt unit beside it
module kdps_back import kdps_pkg::*; #(
  parameter int TREE_SLOTS = TREE_SLOTS_DEFAULT,
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg_regs,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output back_status_t back_status,
  output sqrt_req_t sqrt_req,
  input  sqrt_rsp_t sqrt_rsp,
  kdps_out_if.source result
);
  localparam int IW = $clog2(TREE_SLOTS);
  localparam int HAW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int SW = $clog2(HEAP_DEPTH + 1);

  typedef struct packed {
    logic [2:0] split;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] shape;
    logic [47:0] power;
  } node_t;

  typedef enum logic [17:0] {
    S_CLEAR = 18'h00001,
    S_IDLE  = 18'h00002,
    S_INIT  = 18'h00004,
    S_FETCH = 18'h00008,
    S_WAIT  = 18'h00010,
    S_DEC   = 18'h00020,
    S_SIG   = 18'h00040,
    S_SQ    = 18'h00080,
    S_BR    = 18'h00100,
    S_PT1   = 18'h00200,
    S_PT2   = 18'h00400,
    S_PT3   = 18'h00800,
    S_PT4   = 18'h01000,
    S_HRD   = 18'h02000,
    S_HCMP  = 18'h04000,
    S_FIN   = 18'h08000,
    S_SQRT  = 18'h10000,
    S_DONE  = 18'h20000
  } state_t;

  function automatic logic [32:0] diff33(logic [31:0] a, logic [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  function automatic logic [63:0] square33(logic [32:0] d);
    logic [32:0] neg;
    logic [31:0] mag;
    neg = -d;
    mag = d[32] ? neg[31:0] : d[31:0];
    return 64'(mag) * 64'(mag);
  endfunction

  function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? '1 : s[31:0];
  endfunction

  state_t state;
  cmd_t cmd;

  node_t node_mem [TREE_SLOTS];
  node_t node_rd;
  logic mem_we;
  logic [IW-1:0] mem_waddr;
  node_t mem_wdata;
  logic mem_re;
  logic [IW-1:0] mem_raddr;

  logic [63:0] heap_mem [HEAP_DEPTH];
  logic [63:0] heap_rd;
  logic hp_we;
  logic [HAW-1:0] hp_waddr;
  logic hp_re;

  logic [IW-1:0] clr_idx;
  logic clear_done;
  logic is_knn;
  logic err;
  logic [63:0] bound;
  logic [IW:0] cur;
  logic [IW:0] tnode;
  logic ret_mode;
  logic fetch_go;
  logic [32:0] sigma;
  logic near_bit;
  logic [63:0] sig_sq;
  logic [32:0] dx, dy, dz;
  logic [63:0] sq_x, sq_y, sq_z;
  logic [63:0] dsq;
  logic [31:0] acc_r, acc_g, acc_b;
  logic [10:0] cnt, same;
  logic [63:0] foreign;
  logic [SW-1:0] hsize;
  logic [SW-1:0] keep;
  logic [SW-1:0] scan_idx;
  logic [63:0] max_val;
  logic [HAW-1:0] max_slot;
  logic [63:0] scan_max;
  logic heap_full;
  logic [31:0] root;
  logic [31:0] keep32;
  logic [30:0] rad_sel;
  logic [61:0] rad_sq;
  logic [31:0] axis_q, axis_p;
  logic [31:0] load_ni;
  logic sqrt_start;
  logic res_valid;
  result_t res;
  result_t res_next;

  assign back_status.clear_done = clear_done;
  assign q_pop = (state == S_IDLE) && q_valid;
  assign load_ni = 32'(q_cmd.node_index);
  assign fetch_go = ret_mode ? (cur != (IW+1)'(1)) : (cur < (IW+1)'(TREE_SLOTS));
  assign heap_full = (hsize >= keep);
  assign scan_max = (scan_idx == '0 || heap_rd > max_val) ? heap_rd : max_val;
  assign rad_sel = is_knn ? cfg_regs.start_distance : cmd.search_radius;
  assign rad_sq = 62'(rad_sel) * 62'(rad_sel);

  always_comb begin
    if (cfg_regs.nearest_count == '0) begin
      keep32 = 32'd1;
    end else if (32'(cfg_regs.nearest_count) > 32'(HEAP_DEPTH)) begin
      keep32 = 32'(HEAP_DEPTH);
    end else begin
      keep32 = 32'(cfg_regs.nearest_count);
    end
  end

  always_comb begin
    case (node_rd.split)
      SPLIT_Y: begin
        axis_q = cmd.coord_y;
        axis_p = node_rd.y;
      end
      SPLIT_Z: begin
        axis_q = cmd.coord_z;
        axis_p = node_rd.z;
      end
      default: begin
        axis_q = cmd.coord_x;
        axis_p = node_rd.x;
      end
    endcase
  end

  // node store: clearing pass and loads write, the walker reads
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = clr_idx;
    mem_wdata = '0;
    mem_wdata.split = SPLIT_ABSENT;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (q_pop && q_cmd.op == OP_LOAD) begin
      mem_we = 1'b1;
      mem_waddr = load_ni[IW-1:0];
      mem_wdata.split = q_cmd.split_code;
      mem_wdata.x = q_cmd.coord_x;
      mem_wdata.y = q_cmd.coord_y;
      mem_wdata.z = q_cmd.coord_z;
      mem_wdata.shape = q_cmd.shape_id;
      mem_wdata.power = q_cmd.power;
    end
    mem_re = (state == S_FETCH) && fetch_go;
    mem_raddr = ret_mode ? cur[IW:1] : cur[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      node_rd <= node_mem[mem_raddr];
    end
  end

  always_comb begin
    hp_we = (state == S_PT4) && is_knn && (dsq < bound);
    hp_waddr = heap_full ? max_slot : hsize[HAW-1:0];
    hp_re = (state == S_HRD);
  end

  always_ff @(posedge clk) begin
    if (hp_we) begin
      heap_mem[hp_waddr] <= dsq;
    end
    if (hp_re) begin
      heap_rd <= heap_mem[scan_idx[HAW-1:0]];
    end
  end

  always_comb begin
    res_next = '0;
    case (cmd.op)
      OP_LOAD_BAD: res_next.status = ST_RANGE;
      OP_RADIUS: begin
        if (err) begin
          res_next.status = ST_BAD_SPLIT;
        end else begin
          res_next.sum_red = acc_r;
          res_next.sum_green = acc_g;
          res_next.sum_blue = acc_b;
          res_next.photon_count = cnt;
          res_next.same_shape_count = same;
          res_next.foreign_distance_sq = foreign;
        end
      end
      OP_NEAREST: begin
        if (err) begin
          res_next.status = ST_BAD_SPLIT;
        end else if (hsize == '0) begin
          res_next.nearest_radius = 32'(cfg_regs.start_distance);
        end else begin
          res_next.nearest_radius = root;
        end
      end
      default: ;
    endcase
  end

  assign sqrt_start = (state == S_FIN) && is_knn && !err && (hsize != '0);
  assign sqrt_req = '{start: sqrt_start, value: max_val};

  assign result.valid = res_valid;
  assign result.status = res.status;
  assign result.sum_red = res.sum_red;
  assign result.sum_green = res.sum_green;
  assign result.sum_blue = res.sum_blue;
  assign result.photon_count = res.photon_count;
  assign result.same_shape_count = res.same_shape_count;
  assign result.foreign_distance_sq = res.foreign_distance_sq;
  assign result.nearest_radius = res.nearest_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      clear_done <= 1'b0;
      res_valid <= 1'b0;
      hsize <= '0;
      err <= 1'b0;
    end else begin
      if (res_valid && result.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IW'(TREE_SLOTS - 1)) begin
            clear_done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            err <= 1'b0;
            is_knn <= (q_cmd.op == OP_NEAREST);
            if (q_cmd.op == OP_RADIUS || q_cmd.op == OP_NEAREST) begin
              state <= S_INIT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_INIT: begin
          bound <= 64'(rad_sq);
          foreign <= 64'(rad_sq);
          acc_r <= '0;
          acc_g <= '0;
          acc_b <= '0;
          cnt <= '0;
          same <= '0;
          hsize <= '0;
          keep <= keep32[SW-1:0];
          cur <= (IW+1)'(1);
          ret_mode <= 1'b0;
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (fetch_go) begin
            state <= S_WAIT;
          end else if (ret_mode) begin
            state <= S_FIN;
          end else begin
            ret_mode <= 1'b1;
          end
        end
        S_WAIT: state <= S_DEC;
        S_DEC: begin
          if (ret_mode) begin
            state <= S_SIG;
          end else if (node_rd.split == SPLIT_ABSENT) begin
            ret_mode <= 1'b1;
            state <= S_FETCH;
          end else if (node_rd.split > SPLIT_ABSENT) begin
            err <= 1'b1;
            state <= S_FIN;
          end else if (node_rd.split == SPLIT_LEAF) begin
            tnode <= cur;
            state <= S_PT1;
          end else begin
            state <= S_SIG;
          end
        end
        S_SIG: begin
          sigma <= diff33(axis_q, axis_p);
          state <= S_SQ;
        end
        S_SQ: begin
          sig_sq <= square33(sigma);
          near_bit <= !sigma[32];
          state <= S_BR;
        end
        S_BR: begin
          if (!ret_mode) begin
            cur <= {cur[IW-1:0], near_bit};
            state <= S_FETCH;
          end else if (cur[0] == near_bit && sig_sq < bound) begin
            cur <= {cur[IW:1], !near_bit};
            ret_mode <= 1'b0;
            state <= S_FETCH;
          end else begin
            tnode <= {1'b0, cur[IW:1]};
            state <= S_PT1;
          end
        end
        S_PT1: begin
          dx <= diff33(node_rd.x, cmd.coord_x);
          dy <= diff33(node_rd.y, cmd.coord_y);
          dz <= diff33(node_rd.z, cmd.coord_z);
          state <= S_PT2;
        end
        S_PT2: begin
          sq_x <= square33(dx);
          sq_y <= square33(dy);
          sq_z <= square33(dz);
          state <= S_PT3;
        end
        S_PT3: begin
          dsq <= sat_add64(sat_add64(sq_x, sq_y), sq_z);
          state <= S_PT4;
        end
        S_PT4: begin
          cur <= tnode;
          ret_mode <= 1'b1;
          state <= S_FETCH;
          if (dsq < bound) begin
            if (!is_knn) begin
              acc_r <= sat_add32(acc_r, node_rd.power[47:32]);
              acc_g <= sat_add32(acc_g, node_rd.power[31:16]);
              acc_b <= sat_add32(acc_b, node_rd.power[15:0]);
              if (cnt != COUNT_MAX) begin
                cnt <= cnt + 1'b1;
              end
              if (node_rd.shape == cmd.shape_id) begin
                if (same != COUNT_MAX) begin
                  same <= same + 1'b1;
                end
              end else if (dsq < foreign) begin
                foreign <= dsq;
              end
            end else if (heap_full) begin
              scan_idx <= '0;
              state <= S_HRD;
            end else begin
              if (hsize == '0 || dsq > max_val) begin
                max_val <= dsq;
                max_slot <= hsize[HAW-1:0];
              end
              hsize <= hsize + 1'b1;
            end
          end
        end
        S_HRD: state <= S_HCMP;
        S_HCMP: begin
          max_val <= scan_max;
          if (scan_idx == '0 || heap_rd > max_val) begin
            max_slot <= scan_idx[HAW-1:0];
          end
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == hsize - 1'b1) begin
            bound <= scan_max;
            state <= S_FETCH;
          end else begin
            state <= S_HRD;
          end
        end
        S_FIN: begin
          if (sqrt_start) begin
            state <= S_SQRT;
          end else begin
            state <= S_DONE;
          end
        end
        S_SQRT: begin
          if (sqrt_rsp.done) begin
            root <= sqrt_rsp.root;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res <= res_next;
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/kdps_checker.sv =====
// kdps_checker: assertions on the result port of the photon search top level
// depends on kdps_pkg; bound to kd_tree_photon_search_top below
module kdps_checker import kdps_pkg::*; (
  input logic clk,
  input logic rst,
  input logic result_valid,
  input logic result_ready,
  input logic [1:0] status,
  input logic [31:0] sum_red,
  input logic [10:0] photon_count,
  input logic [10:0] same_shape_count,
  input logic [63:0] foreign_distance_sq,
  input logic [31:0] nearest_radius
);
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> sum_red == '0 && photon_count == '0 &&
    foreign_distance_sq == '0 && nearest_radius == '0)
    else $error("error result carries data");

  a_same_le_count: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> same_shape_count <= photon_count)
    else $error("same shape count above photon count");
endmodule

bind kd_tree_photon_search_top kdps_checker u_checker (
  .clk(clk),
  .rst(rst),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .status(result.status),
  .sum_red(result.sum_red),
  .photon_count(result.photon_count),
  .same_shape_count(result.same_shape_count),
  .foreign_distance_sq(result.foreign_distance_sq),
  .nearest_radius(result.nearest_radius)
);

// ===== tb/sv/kdps_search_checker.sv =====
`timescale 1ns / 1ps
// kdps_search_checker: watches the request, result and cfg channels, predicts each
// result of the kd-tree photon search and compares it field by field
// depends on kdps_pkg and the kdps channel interfaces
module kdps_search_checker import kdps_pkg::*; (
  input  logic clk,
  input  logic rst,
  kdps_in_if item,
  kdps_out_if result,
  kdps_cfg_if cfg,
  output int fail_count,
  output int pending
);

  localparam int SLOTS = 1024;
  localparam int KEEP_MAX = 64;

  logic [2:0] split_mem [SLOTS];
  logic [31:0] pos_x [SLOTS];
  logic [31:0] pos_y [SLOTS];
  logic [31:0] pos_z [SLOTS];
  logic [15:0] shape_mem [SLOTS];
  logic [47:0] power_mem [SLOTS];
  logic [63:0] kept_dist [KEEP_MAX];
  int kept_n;
  logic [6:0] nearest_reg;
  logic [30:0] start_reg;

  longint centre [3];
  logic [15:0] query_shape;
  logic [63:0] bound;
  bit nearest_mode;
  bit walk_err;
  int keep;
  logic [63:0] acc_red, acc_green, acc_blue, acc_foreign;
  int acc_count, acc_same;

  result_t expected_results [$];

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [63:0] sq_mag(longint d);
    logic [63:0] m;
    m = d < 0 ? -d : d;
    return m * m;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    return (a > ~b) ? '1 : a + b;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int largest_slot();
    int best;
    best = 0;
    for (int i = 1; i < kept_n; i++)
      if (kept_dist[i] > kept_dist[best]) best = i;
    return best;
  endfunction

  function automatic void test_photon(int n);
    logic [63:0] d;
    d = sq_mag(sx(pos_x[n]) - centre[0]);
    d = sat_add(d, sq_mag(sx(pos_y[n]) - centre[1]));
    d = sat_add(d, sq_mag(sx(pos_z[n]) - centre[2]));
    if (d >= bound) return;
    if (nearest_mode) begin
      if (kept_n >= keep) begin
        kept_dist[largest_slot()] = d;
        bound = kept_dist[largest_slot()];
      end else if (kept_n < KEEP_MAX) begin
        kept_dist[kept_n] = d;
        kept_n++;
      end
      return;
    end
    acc_red = acc_red + power_mem[n][47:32];
    acc_green = acc_green + power_mem[n][31:16];
    acc_blue = acc_blue + power_mem[n][15:0];
    if (acc_red > 64'hFFFF_FFFF) acc_red = 64'hFFFF_FFFF;
    if (acc_green > 64'hFFFF_FFFF) acc_green = 64'hFFFF_FFFF;
    if (acc_blue > 64'hFFFF_FFFF) acc_blue = 64'hFFFF_FFFF;
    if (acc_count < COUNT_MAX) acc_count++;
    if (shape_mem[n] == query_shape) begin
      if (acc_same < COUNT_MAX) acc_same++;
    end else if (d < acc_foreign) begin
      acc_foreign = d;
    end
  endfunction

  function automatic void walk_node(int n);
    logic [2:0] s;
    int axis;
    longint sigma;
    logic [31:0] p;
    int near_c, far_c;
    if (walk_err || n >= SLOTS) return;
    s = split_mem[n];
    if (s == SPLIT_ABSENT) return;
    if (s > SPLIT_ABSENT) begin
      walk_err = 1;
      return;
    end
    if (s != SPLIT_LEAF) begin
      axis = s - 1;
      p = axis == 0 ? pos_x[n] : (axis == 1 ? pos_y[n] : pos_z[n]);
      sigma = centre[axis] - sx(p);
      near_c = sigma < 0 ? 2 * n : 2 * n + 1;
      far_c = sigma < 0 ? 2 * n + 1 : 2 * n;
      walk_node(near_c);
      if (walk_err) return;
      if (sq_mag(sigma) < bound) walk_node(far_c);
      if (walk_err) return;
    end
    test_photon(n);
  endfunction

  function automatic result_t predict_search();
    result_t r;
    logic [63:0] rad;
    r = '0;
    if (item.kind == KIND_LOAD) begin
      if (item.node_index == 0) begin
        r.status = ST_RANGE;
      end else begin
        split_mem[item.node_index] = item.split_code;
        pos_x[item.node_index] = item.coord_x;
        pos_y[item.node_index] = item.coord_y;
        pos_z[item.node_index] = item.coord_z;
        shape_mem[item.node_index] = item.shape_id;
        power_mem[item.node_index] = {item.power_red, item.power_green, item.power_blue};
      end
      return r;
    end
    if (item.kind != KIND_RADIUS && item.kind != KIND_NEAREST) return r;
    centre[0] = sx(item.coord_x);
    centre[1] = sx(item.coord_y);
    centre[2] = sx(item.coord_z);
    query_shape = item.shape_id;
    walk_err = 0;
    acc_red = 0;
    acc_green = 0;
    acc_blue = 0;
    acc_count = 0;
    acc_same = 0;
    if (item.kind == KIND_RADIUS) begin
      nearest_mode = 0;
      rad = 64'(item.search_radius);
      bound = rad * rad;
      acc_foreign = bound;
      walk_node(1);
      if (walk_err) begin
        r.status = ST_BAD_SPLIT;
        return r;
      end
      r.sum_red = acc_red[31:0];
      r.sum_green = acc_green[31:0];
      r.sum_blue = acc_blue[31:0];
      r.photon_count = 11'(acc_count);
      r.same_shape_count = 11'(acc_same);
      r.foreign_distance_sq = acc_foreign;
      return r;
    end
    nearest_mode = 1;
    keep = nearest_reg == 0 ? 1 : int'(nearest_reg);
    if (keep > KEEP_MAX) keep = KEEP_MAX;
    kept_n = 0;
    rad = 64'(start_reg);
    bound = rad * rad;
    walk_node(1);
    if (walk_err) begin
      r.status = ST_BAD_SPLIT;
      return r;
    end
    if (kept_n == 0) r.nearest_radius = 32'(start_reg);
    else r.nearest_radius = 32'(root64(kept_dist[largest_slot()]));
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) split_mem[i] = SPLIT_ABSENT;
      kept_n = 0;
      nearest_reg = NEAREST_COUNT_RESET;
      start_reg = START_DISTANCE_RESET;
      expected_results.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", 64'(exp_r.status), 64'(result.status));
          check_field("sum_red", 64'(exp_r.sum_red), 64'(result.sum_red));
          check_field("sum_green", 64'(exp_r.sum_green), 64'(result.sum_green));
          check_field("sum_blue", 64'(exp_r.sum_blue), 64'(result.sum_blue));
          check_field("photon_count", 64'(exp_r.photon_count), 64'(result.photon_count));
          check_field("same_shape_count", 64'(exp_r.same_shape_count),
                      64'(result.same_shape_count));
          check_field("foreign_distance_sq", exp_r.foreign_distance_sq,
                      result.foreign_distance_sq);
          check_field("nearest_radius", 64'(exp_r.nearest_radius),
                      64'(result.nearest_radius));
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_NEAREST_COUNT) nearest_reg = cfg.data[6:0];
        else if (cfg.index == CFG_START_DISTANCE) start_reg = cfg.data;
      end
      if (item.valid && item.ready) expected_results.push_back(predict_search());
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/sv/tb_kd_tree_photon_search_top.sv =====
`timescale 1ns / 1ps
// tb_kd_tree_photon_search_top: drives node loads, radius and k-nearest queries with
// random pacing and register changes, and gives the verdict from the checker
// depends on kdps_pkg, kdps_if, kd_tree_photon_search_top and kdps_search_checker
module tb_kd_tree_photon_search_top;
  import kdps_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;

  logic clk = 0;
  logic rst = 1;
  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count, pending;
  int idle_cycles = 0;
  int n_items = 0, n_loads = 0, n_radius = 0, n_nearest = 0;
  int depth;
  int pick;
  logic [9:0] slot;
  int nc_set [4] = '{1, 64, 0, 100};
  logic [30:0] sd_set [4];
  int idle_set [4] = '{0, 47, 0, 21};
  int stall_set [4] = '{0, 0, 47, 21};

  kdps_in_if in_ch();
  kdps_out_if out_ch();
  kdps_cfg_if cfg_ch();

  kd_tree_photon_search_top dut (
    .clk(clk),
    .rst(rst),
    .item(in_ch),
    .result(out_ch),
    .cfg(cfg_ch)
  );

  kdps_search_checker u_checker (
    .clk(clk),
    .rst(rst),
    .item(in_ch),
    .result(out_ch),
    .cfg(cfg_ch),
    .fail_count(fail_count),
    .pending(pending)
  );

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.kind = 0;
    in_ch.node_index = 0;
    in_ch.split_code = 0;
    in_ch.coord_x = 0;
    in_ch.coord_y = 0;
    in_ch.coord_z = 0;
    in_ch.shape_id = 0;
    in_ch.power_red = 0;
    in_ch.power_green = 0;
    in_ch.power_blue = 0;
    in_ch.search_radius = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = 0;
    cfg_ch.data = 0;
  end

  always @(negedge clk) out_ch.ready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[kd_tree_photon_search_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [9:0] n, input logic [2:0] s,
                           input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                           input logic [15:0] sh, input logic [47:0] pw,
                           input logic [30:0] rad);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.kind = k;
    in_ch.node_index = n;
    in_ch.split_code = s;
    in_ch.coord_x = x;
    in_ch.coord_y = y;
    in_ch.coord_z = z;
    in_ch.shape_id = sh;
    {in_ch.power_red, in_ch.power_green, in_ch.power_blue} = pw;
    in_ch.search_radius = rad;
    in_ch.valid = 1;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    if (k == KIND_LOAD) n_loads++;
    else if (k == KIND_RADIUS) n_radius++;
    else if (k == KIND_NEAREST) n_nearest++;
  endtask

  task automatic load_node(input logic [9:0] n, input logic [2:0] s, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z, input logic [15:0] sh,
                           input logic [47:0] pw);
    send_item(KIND_LOAD, n, s, x, y, z, sh, pw, $urandom);
  endtask

  task automatic query(input logic [1:0] k, input logic [31:0] x, input logic [31:0] y,
                       input logic [31:0] z, input logic [15:0] sh, input logic [30:0] rad);
    send_item(k, $urandom, $urandom, x, y, z, sh, {$urandom, $urandom}, rad);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [30:0] d);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data = d;
    cfg_ch.valid = 1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(15) == 0) return $urandom;
    return $urandom_range(0, 32'h10_0000) - 32'h8_0000;
  endfunction

  function automatic logic [15:0] rand_shape();
    if ($urandom_range(7) == 0) return $urandom;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [30:0] rand_radius();
    if ($urandom_range(19) == 0) return $urandom;
    return $urandom_range(0, 32'h18_0000);
  endfunction

  function automatic logic [2:0] rand_split(input int level, input int last);
    if (level == last) return ($urandom_range(3) == 0) ? SPLIT_ABSENT : SPLIT_LEAF;
    pick = $urandom_range(9);
    if (pick == 0) return SPLIT_LEAF;
    if (pick == 1) return SPLIT_ABSENT;
    return $urandom_range(SPLIT_X, SPLIT_Z);
  endfunction

  initial begin
    sd_set[0] = 31'h7FFF_FFFF;
    sd_set[1] = 0;
    sd_set[2] = $urandom_range(32'h1_0000, 32'h20_0000);
    sd_set[3] = 31'h4_0000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: range error, unused kind, a deep chain to the last slot
    load_node(0, SPLIT_LEAF, 0, 0, 0, 0, '1);
    send_item(2'd3, '1, '1, '1, '1, '1, '1, '1, '1);
    slot = 1;
    for (int i = 0; i < 10; i++) begin
      load_node(slot, SPLIT_X + (i % 3), 32'(i) << 14, -(32'(i) << 14), 32'(i) << 12,
                (i % 2) ? 16'hFFFF : 16'h0000, '1);
      slot = {slot[8:0], 1'b1};
    end
    load_node(1023, SPLIT_Z, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, '1);
    query(KIND_RADIUS, 0, 0, 0, 16'h0000, 31'h7FFF_FFFF);
    query(KIND_RADIUS, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF,
          31'h7FFF_FFFF);
    query(KIND_RADIUS, 32'h1_0000, 0, 0, 16'h0001, 0);
    query(KIND_NEAREST, 0, 0, 0, 0, 0);
    query(KIND_NEAREST, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    wait_idle();
    write_reg(CFG_NEAREST_COUNT, 1);
    write_reg(CFG_START_DISTANCE, 31'h7FFF_FFFF);
    query(KIND_NEAREST, 0, 0, 0, 0, 0);
    query(KIND_NEAREST, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0);
    // bad split met on the low side of the root, then put back
    load_node(2, 3'd5, 0, 0, 0, 0, 0);
    query(KIND_RADIUS, 32'hFFF0_0000, 0, 0, 0, 31'h10_0000);
    query(KIND_NEAREST, 32'hFFF0_0000, 0, 0, 0, 0);
    load_node(2, SPLIT_ABSENT, 0, 0, 0, 0, 0);
    query(KIND_RADIUS, 32'hFFF0_0000, 0, 0, 0, 31'h10_0000);

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      write_reg(CFG_NEAREST_COUNT, nc_set[ph]);
      write_reg(CFG_START_DISTANCE, sd_set[ph]);
      depth = $urandom_range(2, 5);
      for (int n = 1; n < (1 << depth); n++)
        load_node(n, rand_split($clog2(n + 1), depth), rand_coord(), rand_coord(),
                  rand_coord(), rand_shape(), {$urandom, $urandom});
      for (int i = 0; i < 130; i++) begin
        if (i == 65) wait_idle();
        pick = $urandom_range(99);
        slot = $urandom_range(1, (1 << depth) - 1);
        if (pick < 40) begin
          query(KIND_RADIUS, rand_coord(), rand_coord(), rand_coord(), rand_shape(),
                rand_radius());
        end else if (pick < 75) begin
          query(KIND_NEAREST, rand_coord(), rand_coord(), rand_coord(), rand_shape(),
                $urandom);
        end else if (pick < 85) begin
          load_node(slot, $urandom_range(SPLIT_LEAF, SPLIT_ABSENT), rand_coord(),
                    rand_coord(), rand_coord(), rand_shape(), {$urandom, $urandom});
        end else if (pick < 90) begin
          load_node(slot, $urandom_range(5, 7), rand_coord(), rand_coord(), rand_coord(),
                    rand_shape(), {$urandom, $urandom});
          query(KIND_RADIUS, rand_coord(), rand_coord(), rand_coord(), rand_shape(),
                31'h7FFF_FFFF);
          load_node(slot, SPLIT_LEAF, rand_coord(), rand_coord(), rand_coord(),
                    rand_shape(), {$urandom, $urandom});
        end else if (pick < 95) begin
          send_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    {$urandom, $urandom}, $urandom);
        end else begin
          load_node(0, $urandom, $urandom, $urandom, $urandom, $urandom,
                    {$urandom, $urandom});
        end
      end
    end

    wait_idle();
    repeat (50) @(negedge clk);
    $display("covered %0d requests: %0d loads, %0d radius and %0d k-nearest queries",
             n_items, n_loads, n_radius, n_nearest);
    $display("four pacing phases with nearest_count and start_distance at their extremes");
    if (fail_count == 0 && pending == 0) begin
      $display("[kd_tree_photon_search_top] OK");
    end else begin
      $display("[kd_tree_photon_search_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/kdps_pkg.sv
rtl/core/kdps_if.sv
rtl/core/kdps_fifo.sv
rtl/core/kdps_front.sv
rtl/core/kdps_sqrt.sv
rtl/core/kdps_back.sv
rtl/core/kd_tree_photon_search_top.sv
rtl/core/kdps_checker.sv
tb/sv/kdps_search_checker.sv
tb/sv/tb_kd_tree_photon_search_top.sv
